>>> src/utf16_to_html_escaped_utf8_unit_assert.svh
// assertion macros for the transcoder rtl
`ifndef UTF16_TO_HTML_ESCAPED_UTF8_UNIT_ASSERT_SVH
`define UTF16_TO_HTML_ESCAPED_UTF8_UNIT_ASSERT_SVH

// condition must hold at every edge out of reset
`define U16H_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define U16H_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/u16h_pkg.sv
// types, constants and byte generation functions for the utf-16 to escaped utf-8 unit
package u16h_pkg;

   typedef enum logic [3:0] {
      KIND_NONE,
      KIND_ONE,
      KIND_TWO,
      KIND_THREE,
      KIND_FOUR,
      KIND_AMP,
      KIND_LT,
      KIND_GT,
      KIND_BR,
      KIND_TAB
   } kind_type;

   typedef struct packed {
      logic        flush;
      logic [9:0]  flush_payload;
      kind_type    kind;
      logic [20:0] code_point;
   } cmd_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_item;
   } rsp_type;

   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;
   localparam logic [7:0] CONT_BYTE  = 8'h80;
   localparam logic [5:0] HIGH_TAG   = 6'b110110;
   localparam logic [5:0] LOW_TAG    = 6'b110111;
   localparam logic [20:0] SUPP_BASE = 21'h10000;
   localparam logic [2:0] FLUSH_LEN  = 3'd3;

   // entity texts, left aligned and zero padded to five bytes
   localparam logic [39:0] AMP_TEXT = "&amp;";
   localparam logic [39:0] LT_TEXT  = {"&lt;", 8'h00};
   localparam logic [39:0] GT_TEXT  = {"&gt;", 8'h00};
   localparam logic [39:0] BR_TEXT  = "<br/>";
   localparam logic [39:0] TAB_TEXT = {"&#9;", 8'h00};

   function automatic kind_type classify(input logic [15:0] unit);
      kind_type k;
      priority if (unit == 16'h0026) k = KIND_AMP;
      else if (unit == 16'h003C) k = KIND_LT;
      else if (unit == 16'h003E) k = KIND_GT;
      else if (unit == 16'h000A) k = KIND_BR;
      else if (unit == 16'h0009) k = KIND_TAB;
      else if (unit < 16'h0020) k = KIND_NONE;
      else if (unit < 16'h0080) k = KIND_ONE;
      else if (unit < 16'h0800) k = KIND_TWO;
      else k = KIND_THREE;
      return k;
   endfunction

   function automatic logic [3:0] cmd_length(input cmd_type cmd);
      logic [3:0] body;
      unique case (cmd.kind)
         KIND_NONE:  body = 4'd0;
         KIND_ONE:   body = 4'd1;
         KIND_TWO:   body = 4'd2;
         KIND_THREE: body = 4'd3;
         KIND_FOUR:  body = 4'd4;
         KIND_AMP:   body = 4'd5;
         KIND_LT:    body = 4'd4;
         KIND_GT:    body = 4'd4;
         KIND_BR:    body = 4'd5;
         KIND_TAB:   body = 4'd4;
         default:    body = 4'd0;
      endcase
      return body + (cmd.flush ? {1'b0, FLUSH_LEN} : 4'd0);
   endfunction

   function automatic logic [7:0] text_byte(input logic [39:0] txt, input logic [2:0] j);
      logic [7:0] b;
      case (j)
         3'd0:    b = txt[39:32];
         3'd1:    b = txt[31:24];
         3'd2:    b = txt[23:16];
         3'd3:    b = txt[15:8];
         3'd4:    b = txt[7:0];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] cmd_byte(input cmd_type cmd, input logic [2:0] idx);
      logic [15:0] sur;
      logic [2:0]  j;
      logic [20:0] cp;
      logic [7:0]  b;
      sur = {HIGH_TAG, cmd.flush_payload};
      cp  = cmd.code_point;
      j   = cmd.flush ? idx - FLUSH_LEN : idx;
      b   = 8'h00;
      if (cmd.flush && idx < FLUSH_LEN) begin
         case (idx[1:0])
            2'd0:    b = LEAD_THREE | {4'h0, sur[15:12]};
            2'd1:    b = CONT_BYTE | {2'b00, sur[11:6]};
            default: b = CONT_BYTE | {2'b00, sur[5:0]};
         endcase
      end else begin
         unique case (cmd.kind)
            KIND_ONE: b = cp[7:0];
            KIND_TWO: begin
               if (j == 3'd0) b = LEAD_TWO | {3'b000, cp[10:6]};
               else b = CONT_BYTE | {2'b00, cp[5:0]};
            end
            KIND_THREE: begin
               case (j)
                  3'd0:    b = LEAD_THREE | {4'h0, cp[15:12]};
                  3'd1:    b = CONT_BYTE | {2'b00, cp[11:6]};
                  default: b = CONT_BYTE | {2'b00, cp[5:0]};
               endcase
            end
            KIND_FOUR: begin
               case (j)
                  3'd0:    b = LEAD_FOUR | {5'h00, cp[20:18]};
                  3'd1:    b = CONT_BYTE | {2'b00, cp[17:12]};
                  3'd2:    b = CONT_BYTE | {2'b00, cp[11:6]};
                  default: b = CONT_BYTE | {2'b00, cp[5:0]};
               endcase
            end
            KIND_AMP: b = text_byte(AMP_TEXT, j);
            KIND_LT:  b = text_byte(LT_TEXT, j);
            KIND_GT:  b = text_byte(GT_TEXT, j);
            KIND_BR:  b = text_byte(BR_TEXT, j);
            KIND_TAB: b = text_byte(TAB_TEXT, j);
            default:  b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage

>>> src/u16h_fifo.sv
// two-entry queue with full and empty flags
module u16h_fifo #(
   parameter int Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] rdata,
   output logic             empty
);

   logic [Width-1:0] mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> src/u16h_front.sv
// front end: surrogate pairing and classification of each code unit into a command
module u16h_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  logic [15:0]     req_code_unit,
   input  logic            req_last_unit,
   output logic            cmd_push,
   output u16h_pkg::cmd_type cmd_data,
   input  logic            cmd_full
);

   logic       held_valid_ff, held_valid_in;
   logic [9:0] held_payload_ff, held_payload_in;
   logic       accept, is_high, is_low;

   assign full    = cmd_full;
   assign accept  = push && !cmd_full;
   assign is_high = (req_code_unit[15:10] == u16h_pkg::HIGH_TAG);
   assign is_low  = (req_code_unit[15:10] == u16h_pkg::LOW_TAG);

   always_comb begin
      cmd_data.flush         = 1'b0;
      cmd_data.flush_payload = held_payload_ff;
      cmd_data.kind          = u16h_pkg::KIND_NONE;
      cmd_data.code_point    = {5'd0, req_code_unit};
      held_valid_in          = 1'b0;
      held_payload_in        = 10'd0;
      if (held_valid_ff && is_low) begin
         cmd_data.kind       = u16h_pkg::KIND_FOUR;
         cmd_data.code_point = u16h_pkg::SUPP_BASE
                               + {1'b0, held_payload_ff, req_code_unit[9:0]};
      end else begin
         cmd_data.flush = held_valid_ff;
         if (is_high && !req_last_unit) begin
            held_valid_in   = 1'b1;
            held_payload_in = req_code_unit[9:0];
         end else begin
            cmd_data.kind = u16h_pkg::classify(req_code_unit);
         end
      end
   end

   // dropped controls and newly held surrogates produce no command unless a held surrogate is flushed
   assign cmd_push = accept && (cmd_data.flush || cmd_data.kind != u16h_pkg::KIND_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff   <= 1'b0;
         held_payload_ff <= 10'd0;
      end else if (accept) begin
         held_valid_ff   <= held_valid_in;
         held_payload_ff <= held_payload_in;
      end
   end

endmodule

>>> src/u16h_back.sv
// back end: expands one command into its byte sequence, one byte per cycle while the result queue is not full
module u16h_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  u16h_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              rsp_push,
   output u16h_pkg::rsp_type rsp_data,
   input  logic              rsp_full
);

   `include "utf16_to_html_escaped_utf8_unit_assert.svh"

   logic [2:0] idx_ff, idx_in;
   logic [3:0] total;
   logic       done;

   assign total    = u16h_pkg::cmd_length(cmd_data);
   assign done     = ({1'b0, idx_ff} == total - 4'd1);
   assign rsp_push = cmd_valid && !rsp_full;
   assign cmd_pop  = rsp_push && done;

   always_comb begin
      rsp_data.out_byte     = u16h_pkg::cmd_byte(cmd_data, idx_ff);
      rsp_data.last_of_item = done;
      idx_in = idx_ff;
      if (rsp_push) begin
         idx_in = done ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   `U16H_ASSERT_ALWAYS(a_idx_in_range, !cmd_valid || ({1'b0, idx_ff} < total), "byte index past command length")
   `U16H_ASSERT_ALWAYS(a_cmd_not_empty, !cmd_valid || (total != 4'd0), "queued command has no bytes")
   `U16H_ASSERT_NEXT(a_idx_restart, cmd_pop, idx_ff == 3'd0, "byte index not cleared after command")
   `U16H_ASSERT_NEXT(a_stall_hold, cmd_valid && rsp_full, $stable(idx_ff), "byte index moved while stalled")

endmodule

>>> src/utf16_to_html_escaped_utf8_unit.sv
// the first byte of a unit is registered in the command queue and then in the result queue before it is poppable
// throughput: one output byte per cycle while the result queue is not full, set by the byte expander in the back end
// a single-byte unit therefore sustains one unit per cycle; an n-byte unit holds the back end for all n bytes
// a command queue and a result queue of two entries each decouple the front end, the back end and the output port
// reset: synchronous, active high; clears the held surrogate and both queues
module utf16_to_html_escaped_utf8_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_item
);

   u16h_pkg::cmd_type cmd_wdata, cmd_rdata;
   u16h_pkg::rsp_type rsp_wdata, rsp_rdata;
   logic cmd_push, cmd_full, cmd_empty, cmd_pop;
   logic rsp_push, rsp_full;

   u16h_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_code_unit (req_code_unit),
      .req_last_unit (req_last_unit),
      .cmd_push      (cmd_push),
      .cmd_data      (cmd_wdata),
      .cmd_full      (cmd_full)
   );

   u16h_fifo #(.Width($bits(u16h_pkg::cmd_type))) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wdata),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd_rdata),
      .empty (cmd_empty)
   );

   u16h_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd_data  (cmd_rdata),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_wdata),
      .rsp_full  (rsp_full)
   );

   u16h_fifo #(.Width($bits(u16h_pkg::rsp_type))) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_rdata),
      .empty (empty)
   );

   assign rsp_out_byte     = rsp_rdata.out_byte;
   assign rsp_last_of_item = rsp_rdata.last_of_item;

endmodule
